FILE: rtl/indexed_list_insert_remove_macros.svh
// Assertion helpers for the indexed list block.
// Both expect a clock named i_clk and an active-low reset named i_rst_n.
`ifndef INDEXED_LIST_INSERT_REMOVE_MACROS_SVH
`define INDEXED_LIST_INSERT_REMOVE_MACROS_SVH

// Same-cycle implication.
`define ILIR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ilir assertion failed");

// Next-cycle implication.
`define ILIR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ilir assertion failed");

`endif

FILE: rtl/ilir_pkg.sv
package ilir_pkg;

    // Fixed geometry of the list
    localparam int CAPACITY   = 64;
    localparam int WORD_WIDTH = 32;
    localparam int CMD_W      = 3;
    localparam int CNT_W      = 7;
    localparam int STAT_W     = 2;
    localparam int IDX_W      = $clog2(CAPACITY);

    typedef logic [WORD_WIDTH-1:0] t_word;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CMD_W-1:0]      t_cmd;
    typedef logic [STAT_W-1:0]     t_stat;
    typedef logic [1:0]            t_cell_op;

    localparam t_cnt CAP_CNT = t_cnt'(CAPACITY);

    // Command codes
    localparam t_cmd CMD_PUSH   = 3'd0;
    localparam t_cmd CMD_POP    = 3'd1;
    localparam t_cmd CMD_INSERT = 3'd2;
    localparam t_cmd CMD_REMOVE = 3'd3;
    localparam t_cmd CMD_READ   = 3'd4;
    localparam t_cmd CMD_WRITE  = 3'd5;

    // Status codes
    localparam t_stat STAT_OK    = 2'd0;
    localparam t_stat STAT_EMPTY = 2'd1;
    localparam t_stat STAT_RANGE = 2'd2;
    localparam t_stat STAT_FULL  = 2'd3;

    // Cell operations broadcast along the row
    localparam t_cell_op CELL_HOLD   = 2'd0;
    localparam t_cell_op CELL_LOAD   = 2'd1;
    localparam t_cell_op CELL_INSERT = 2'd2;
    localparam t_cell_op CELL_REMOVE = 2'd3;

    typedef struct packed {
        t_cell_op op;
        t_cnt     pos;
        t_cnt     count;
    } t_cell_ctrl;

endpackage

FILE: rtl/ilir_intf.sv
// Command channel: one list command per transaction
interface ilir_cmd_if;
    import ilir_pkg::*;
    logic  valid;
    logic  ready;
    t_cmd  cmd;
    t_cnt  position;
    t_word value;
    modport source(output valid, cmd, position, value, input ready);
    modport sink(input valid, cmd, position, value, output ready);
endinterface

// Response channel: one result per command
interface ilir_rsp_if;
    import ilir_pkg::*;
    logic  valid;
    logic  ready;
    t_word word_out;
    t_cnt  count;
    t_stat status;
    modport source(output valid, word_out, count, status, input ready);
    modport sink(input valid, word_out, count, status, output ready);
endinterface

FILE: rtl/ilir_cell.sv
module ilir_cell (
    input  logic                i_clk,
    input  ilir_pkg::t_cnt      i_index,
    input  ilir_pkg::t_cell_ctrl i_ctrl,
    input  ilir_pkg::t_word     i_value,
    input  ilir_pkg::t_word     i_lower,
    input  ilir_pkg::t_word     i_upper,
    output ilir_pkg::t_word     o_data
);
    import ilir_pkg::*;

    t_word r_data;
    t_word n_data;

    // Local decision from the broadcast op and this cell's place in the row
    always_comb begin
        n_data = r_data;
        case (i_ctrl.op)
            CELL_HOLD: begin
                n_data = r_data;
            end
            CELL_LOAD: begin
                if (i_index == i_ctrl.pos) begin
                    n_data = i_value;
                end
            end
            CELL_INSERT: begin
                if (i_index == i_ctrl.pos) begin
                    n_data = i_value;
                end else if (i_index > i_ctrl.pos && i_index <= i_ctrl.count) begin
                    n_data = i_lower;
                end
            end
            CELL_REMOVE: begin
                if (i_index >= i_ctrl.pos && (i_index + 1'b1) < i_ctrl.count) begin
                    n_data = i_upper;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

FILE: rtl/indexed_list_insert_remove.sv
// The result is registered and valid in the cycle after its command transaction.
// One command per cycle unless a result waits; the row of cells shifts all together.
// A waiting result holds off the next command until it is taken; a command is
// accepted in the same cycle as the result ahead of it leaves.
// Reset clears the element count and the result valid flag; element words are
// not cleared and are only read below the count.
module indexed_list_insert_remove (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ilir_cmd_if.sink   i_cmd,
    ilir_rsp_if.source o_rsp
);
    import ilir_pkg::*;
    `include "indexed_list_insert_remove_macros.svh"

    t_cnt       r_count;
    t_cnt       n_count;
    logic       r_out_valid;
    t_word      r_word;
    t_cnt       r_out_count;
    t_stat      r_status;

    logic       w_accept;
    t_stat      w_status;
    t_word      w_word;
    t_idx       w_rd_idx;
    t_word      w_rd_word;
    t_cell_ctrl w_ctrl;
    t_word      w_cell_q [CAPACITY];
    logic       w_push_ok;
    logic       w_reject;

    assign i_cmd.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    // Single read port over the row: pop reads the last entry, read its index
    assign w_rd_idx  = (i_cmd.cmd == CMD_POP) ? IDX_W'(r_count - 1'b1)
                                              : i_cmd.position[IDX_W-1:0];
    assign w_rd_word = w_cell_q[w_rd_idx];

    // Command decode and checks
    always_comb begin
        n_count       = r_count;
        w_status      = STAT_OK;
        w_word        = '0;
        w_ctrl.op     = CELL_HOLD;
        w_ctrl.pos    = i_cmd.position;
        w_ctrl.count  = r_count;
        case (i_cmd.cmd)
            CMD_PUSH: begin
                if (r_count >= CAP_CNT) begin
                    w_status = STAT_FULL;
                end else begin
                    w_ctrl.op  = CELL_INSERT;
                    w_ctrl.pos = r_count;
                    n_count    = r_count + 1'b1;
                end
            end
            CMD_POP: begin
                if (r_count == '0) begin
                    w_status = STAT_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                    w_word  = w_rd_word;
                end
            end
            CMD_INSERT: begin
                if (i_cmd.position > r_count) begin
                    w_status = STAT_RANGE;
                end else if (r_count >= CAP_CNT) begin
                    w_status = STAT_FULL;
                end else begin
                    w_ctrl.op = CELL_INSERT;
                    n_count   = r_count + 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (i_cmd.position >= r_count) begin
                    w_status = STAT_RANGE;
                end else begin
                    w_ctrl.op = CELL_REMOVE;
                    n_count   = r_count - 1'b1;
                end
            end
            CMD_READ: begin
                if (i_cmd.position >= r_count) begin
                    w_status = STAT_RANGE;
                end else begin
                    w_word = w_rd_word;
                end
            end
            CMD_WRITE: begin
                if (i_cmd.position >= r_count) begin
                    w_status = STAT_RANGE;
                end else begin
                    w_ctrl.op = CELL_LOAD;
                end
            end
            default: begin
                w_status = STAT_OK;
            end
        endcase
        if (!w_accept) begin
            w_ctrl.op = CELL_HOLD;
        end
    end

    // Row of element cells, each wired to its neighbors; the end cells see zero outside
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_word w_lower;
        t_word w_upper;
        if (g == 0) begin : g_first
            assign w_lower = '0;
        end else begin : g_mid_lo
            assign w_lower = w_cell_q[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_upper = '0;
        end else begin : g_mid_hi
            assign w_upper = w_cell_q[g+1];
        end
        ilir_cell u_cell (
            .i_clk   (i_clk),
            .i_index (t_cnt'(g)),
            .i_ctrl  (w_ctrl),
            .i_value (i_cmd.value),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .o_data  (w_cell_q[g])
        );
    end

    // Element count and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_word      <= w_word;
            r_out_count <= n_count;
            r_status    <= w_status;
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.word_out = r_word;
    assign o_rsp.count    = r_out_count;
    assign o_rsp.status   = r_status;

    // Qualifiers for the checks below
    assign w_push_ok = w_accept && w_status == STAT_OK && i_cmd.cmd == CMD_PUSH;
    assign w_reject  = w_accept && w_status != STAT_OK;

    `ILIR_ASSERT_NOW(a_count_max, 1'b1, r_count <= CAP_CNT)
    `ILIR_ASSERT_NEXT(a_push_grows, w_push_ok, r_count == $past(r_count) + 1'b1)
    `ILIR_ASSERT_NEXT(a_reject_keeps, w_reject, $stable(r_count))
    `ILIR_ASSERT_NEXT(a_reject_zero, w_reject, r_word == '0 && r_out_count == $past(r_count))

endmodule
